[design/tsc_pkg.sv]
// shared types and constants for the timestamp counter block
// request codes, register indexes, conversion scale factors, state types and the divider result
// no dependencies
package tsc_pkg;

  localparam int CountW = 32;
  localparam int ScaleW = 24;
  localparam int ProdW  = CountW + ScaleW;

  // configuration register indexes
  localparam logic CFG_CLOCK_HZ  = 1'b0;
  localparam logic CFG_TIMER_EN  = 1'b1;

  // scale factors: microseconds and tenths of a microsecond per second
  localparam logic [ScaleW-1:0] US_PER_SEC     = 24'd1000000;
  localparam logic [ScaleW-1:0] US_X10_PER_SEC = 24'd10000000;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_READ       = 3'd1,
    REQ_ELAPSED    = 3'd2,
    REQ_ELAP_US    = 3'd3,
    REQ_ELAP_US10  = 3'd4,
    REQ_CNT_US     = 3'd5,
    REQ_CNT_US10   = 3'd6
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef enum logic {
    DIV_IDLE,
    DIV_RUN
  } div_state_t;

  // divider status handed back to the controller
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [CountW-1:0] quotient;
  } div_res_t;

endpackage

[design/tsc_div.sv]
// iterative restoring divider, one quotient bit per cycle, with 32-bit clamp
// divides a 56-bit product by the 32-bit clock rate
// depends on tsc_pkg
module tsc_div
  import tsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ProdW-1:0]  dividend,
  input  logic [CountW-1:0] divisor,
  output div_res_t          res
);

  localparam int CntW = $clog2(CountW);

  div_state_t        state;
  div_state_t        state_next;
  logic [CountW-1:0] dvs;
  logic [CountW-1:0] rem;
  logic [CountW-1:0] quo;
  logic [CntW-1:0]   cnt;
  logic              done;
  logic              sat;

  logic [CountW:0]   rem_sh;
  logic [CountW+1:0] diff;
  logic              ge;
  logic [ProdW-CountW-1:0] upper;

  assign upper  = dividend[ProdW-1:CountW];
  assign rem_sh = {rem, quo[CountW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = !diff[CountW+1];

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: begin
        if (start && divisor != '0 && {{(CountW-(ProdW-CountW)){1'b0}}, upper} < divisor) begin
          state_next = DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (cnt == CntW'(CountW - 1)) begin
          state_next = DIV_IDLE;
        end
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      case (state)
        DIV_IDLE: begin
          // zero rate and overflow are settled before iterating
          if (start && divisor == '0) begin
            done <= 1'b1;
          end else if (start && state_next == DIV_IDLE) begin
            done <= 1'b1;
          end
        end
        DIV_RUN: begin
          if (state_next == DIV_IDLE) begin
            done <= 1'b1;
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          dvs <= divisor;
          cnt <= '0;
          rem <= {{(CountW-(ProdW-CountW)){1'b0}}, upper};
          if (divisor == '0) begin
            quo <= '0;
            sat <= 1'b0;
          end else if ({{(CountW-(ProdW-CountW)){1'b0}}, upper} >= divisor) begin
            // quotient needs more than 32 bits
            quo <= '1;
            sat <= 1'b1;
          end else begin
            quo <= dividend[CountW-1:0];
            sat <= 1'b0;
          end
        end
      end
      DIV_RUN: begin
        rem <= ge ? diff[CountW-1:0] : rem_sh[CountW-1:0];
        quo <= {quo[CountW-2:0], ge};
        cnt <= cnt + 1'b1;
      end
      default: cnt <= '0;
    endcase
  end

  assign res.done     = done;
  assign res.sat      = sat;
  assign res.quotient = quo;

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    state == DIV_RUN |-> rem < dvs)
    else $error("partial remainder not below divisor");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (rst)
    done && sat |-> quo == '1)
    else $error("saturated quotient not clamped");

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    !(start && state == DIV_RUN))
    else $error("divider started while busy");
`endif

endmodule

[design/timestamp_counter_with_unit_convert.sv]
// 32-bit timestamp counter advanced by tick requests, with conversion to microseconds
// read and elapsed results are registered at the transfer; a tick produces no result
// a conversion runs multiply, divider load, 32 divider iterations in tsc_div, quotient capture
// and output load, which waits for a free output register; no new request is taken meanwhile
// zero rate or a clamped quotient skips the iterations
// one item at a time; sync active-high reset clears counter, config, state and out_valid
module timestamp_counter_with_unit_convert
  import tsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CountW-1:0] cfg_data,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [CountW-1:0] operand_count,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CountW-1:0] result_value,
  output logic              saturated
);

  state_t            state;
  state_t            state_next;

  // configuration and counter
  logic [CountW-1:0] clock_hz;
  logic              timer_enabled;
  logic [CountW-1:0] tick_counter;

  // conversion datapath
  logic [CountW-1:0] conv_count;
  logic [ScaleW-1:0] conv_scale;
  logic [ProdW-1:0]  product;
  logic [CountW-1:0] hold_value;
  logic              hold_sat;
  div_res_t          div_res;
  logic              div_start;

  logic              in_xfer;
  logic              out_free;
  logic              imm_load;
  logic              hold_load;
  logic [CountW-1:0] now_val;
  logic [CountW-1:0] elapsed_val;

  // a transfer on the result side frees the output register this cycle
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign div_start = (state == ST_START);

  // counter reads as zero while disabled
  assign now_val     = timer_enabled ? tick_counter : '0;
  assign elapsed_val = timer_enabled ? (tick_counter - operand_count) : '0;

  // next state and load strobes
  always_comb begin
    state_next = state;
    imm_load   = 1'b0;
    hold_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          case (req_type)
            REQ_READ, REQ_ELAPSED: imm_load = 1'b1;
            REQ_ELAP_US, REQ_ELAP_US10,
            REQ_CNT_US, REQ_CNT_US10: state_next = ST_MUL;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_MUL:   state_next = ST_START;
      ST_START: state_next = ST_DIV;
      ST_DIV: begin
        if (div_res.done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          hold_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers and the tick counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz      <= '0;
      timer_enabled <= 1'b0;
      tick_counter  <= '0;
    end else begin
      if (in_xfer && req_type == REQ_TICK) begin
        tick_counter <= timer_enabled ? tick_counter + 1'b1 : '0;
      end
      if (cfg_we && cfg_index == CFG_CLOCK_HZ) begin
        clock_hz <= cfg_data;
      end
      if (cfg_we && cfg_index == CFG_TIMER_EN) begin
        timer_enabled <= cfg_data[0];
        // disabling holds the counter at zero
        if (!cfg_data[0]) begin
          tick_counter <= '0;
        end
      end
    end
  end

  // operand capture, product register and divider result holding
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_xfer) begin
      case (req_type)
        REQ_ELAP_US: begin
          conv_count <= elapsed_val;
          conv_scale <= US_PER_SEC;
        end
        REQ_ELAP_US10: begin
          conv_count <= elapsed_val;
          conv_scale <= US_X10_PER_SEC;
        end
        REQ_CNT_US: begin
          conv_count <= operand_count;
          conv_scale <= US_PER_SEC;
        end
        REQ_CNT_US10: begin
          conv_count <= operand_count;
          conv_scale <= US_X10_PER_SEC;
        end
        default: conv_count <= conv_count;
      endcase
    end
    if (state == ST_MUL) begin
      product <= ProdW'(conv_count) * ProdW'(conv_scale);
    end
    if (state == ST_DIV && div_res.done) begin
      hold_value <= div_res.quotient;
      hold_sat   <= div_res.sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (imm_load || hold_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (imm_load) begin
      result_value <= (req_type == REQ_READ) ? now_val : elapsed_val;
      saturated    <= 1'b0;
    end else if (hold_load) begin
      result_value <= hold_value;
      saturated    <= hold_sat;
    end
  end

  tsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (clock_hz),
    .res      (div_res)
  );

`ifndef SYNTH
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> result_value == '1)
    else $error("saturated result not clamped");

  a_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    !timer_enabled |-> tick_counter == '0)
    else $error("counter not held at zero while disabled");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for timestamp_counter_with_unit_convert
// holds its own predictor of the count and unit conversion in a small class
// depends on tsc_pkg and the block under test only
module tb_top;
  import tsc_pkg::*;

  localparam int          HALF_PERIOD   = 10;
  localparam int          RESET_CYCLES  = 8;
  // leave headroom for any conversion still running before touching registers
  localparam int          SETTLE_CYCLES = 50;
  localparam int          IDLE_PCT      = 18;
  localparam longint      LIMIT_NS      = 10_000_000;
  localparam logic [2:0]  REQ_UNUSED    = 3'd7;
  localparam logic [63:0] SCALE_US      = 64'd1_000_000;
  localparam logic [63:0] SCALE_US10    = 64'd10_000_000;

  // one expected result of a request
  typedef struct packed {
    logic        sat;
    logic [31:0] value;
  } reading_t;

  // predictor plus the queue of readings still owed by the block
  class timestamp_ledger;
    logic [31:0] rate_hz;
    logic        running;
    logic [31:0] ticks;
    reading_t    due_readings[$];
    int          errors;

    function new();
      rate_hz = '0;
      running = 1'b0;
      ticks   = '0;
      errors  = 0;
    endfunction

    // count * scale / rate, clamped to 32 bits
    function reading_t to_units(logic [31:0] cnt, logic [63:0] scale);
      reading_t    r;
      logic [63:0] quot;
      r = '0;
      if (rate_hz != 0) begin
        quot = ({32'd0, cnt} * scale) / {32'd0, rate_hz};
        if (quot > 64'hFFFF_FFFF) begin
          r.sat   = 1'b1;
          r.value = 32'hFFFF_FFFF;
        end else begin
          r.value = quot[31:0];
        end
      end
      return r;
    endfunction

    function void take_setting(logic idx, logic [31:0] data);
      if (idx == CFG_CLOCK_HZ) begin
        rate_hz = data;
      end else begin
        running = data[0];
        // disabling clears the count
        if (!running) ticks = '0;
      end
    endfunction

    function void take_request(logic [2:0] kind, logic [31:0] opnd);
      logic [31:0] now;
      logic [31:0] since;
      reading_t    r;
      now   = running ? ticks : 32'd0;
      since = running ? now - opnd : 32'd0;
      r     = '0;
      case (kind)
        REQ_TICK: begin
          ticks = running ? ticks + 32'd1 : 32'd0;
          return;
        end
        REQ_READ:      r.value = now;
        REQ_ELAPSED:   r.value = since;
        REQ_ELAP_US:   r = to_units(since, SCALE_US);
        REQ_ELAP_US10: r = to_units(since, SCALE_US10);
        REQ_CNT_US:    r = to_units(opnd, SCALE_US);
        REQ_CNT_US10:  r = to_units(opnd, SCALE_US10);
        default:       return;
      endcase
      due_readings.push_back(r);
    endfunction

    function void match_reading(logic [31:0] value, logic sat);
      reading_t want;
      if (due_readings.size() == 0) begin
        $display("%0t: result with nothing expected: value %h saturated %0b",
                 $time, value, sat);
        errors++;
        return;
      end
      want = due_readings.pop_front();
      if (value !== want.value) begin
        $display("%0t: result_value mismatch: expected %h actual %h",
                 $time, want.value, value);
        errors++;
      end
      if (sat !== want.sat) begin
        $display("%0t: saturated mismatch: expected %0b actual %0b",
                 $time, want.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  req_type;
  logic [31:0] operand_count;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] result_value;
  logic        saturated;

  timestamp_ledger ledger;
  // random idling on both channels; cleared for one long stretch
  bit          gaps_on;
  // previous-cycle view of a stalled result, for the hold check
  logic        held;
  logic [31:0] held_value;
  logic        held_sat;

  timestamp_counter_with_unit_convert u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .operand_count(operand_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .saturated    (saturated)
  );

  always #HALF_PERIOD clk = ~clk;

  // receiver: stall at random, changed on the falling edge only
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  // monitor: note accepted requests first, then check the result transfer
  always @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      if (in_valid && !in_stall) ledger.take_request(req_type, operand_count);
      if (out_valid && !out_stall) ledger.match_reading(result_value, saturated);
      // a stalled result must stay put until it is taken
      if (held && !(out_valid && result_value === held_value && saturated === held_sat))
      begin
        $display("%0t: stalled result changed: expected %h/%0b actual %h/%0b valid %0b",
                 $time, held_value, held_sat, result_value, saturated, out_valid);
        ledger.errors++;
      end
      held       <= out_valid && out_stall;
      held_value <= result_value;
      held_sat   <= saturated;
    end
  end

  // one request transfer, with random idle cycles ahead of it
  task automatic push_req(input logic [2:0] kind, input logic [31:0] opnd);
    @(negedge clk);
    while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid <= 1'b0;
      req_type <= 3'($urandom());
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    req_type      <= kind;
    operand_count <= opnd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // let every owed result arrive and any tick in hand finish
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.due_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ledger.take_setting(idx, data);
  endtask

  // random request: ticks dominate so the count moves, operands often sit
  // close to the count so elapsed values stay meaningful
  task automatic random_item(input int unsigned tick_pct);
    logic [2:0]  kind;
    logic [31:0] opnd;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < tick_pct) kind = REQ_TICK;
    else if (pick < tick_pct + 3) kind = REQ_UNUSED;
    else kind = 3'($urandom_range(int'(REQ_CNT_US10), int'(REQ_READ)));
    case ($urandom_range(5))
      0:       opnd = $urandom();
      1:       opnd = $urandom_range(255);
      2:       opnd = ledger.ticks - $urandom_range(63);
      3:       opnd = ledger.ticks + $urandom_range(15);
      4:       opnd = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: opnd = $urandom() >> $urandom_range(31);
    endcase
    push_req(kind, opnd);
  endtask

  task automatic run_phase(input logic [31:0] hz, input logic en, input bit gaps,
                           input int unsigned count, input int unsigned tick_pct);
    wait_idle();
    write_reg(CFG_CLOCK_HZ, hz);
    // upper data bits are don't-care for the enable register
    write_reg(CFG_TIMER_EN, {31'($urandom()), en});
    gaps_on = gaps;
    repeat (count) random_item(tick_pct);
  endtask

  initial begin
    #LIMIT_NS;
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = CFG_CLOCK_HZ;
    cfg_data      = '0;
    in_valid      = 1'b0;
    req_type      = REQ_TICK;
    operand_count = '0;
    out_stall     = 1'b0;
    held          = 1'b0;
    held_value    = '0;
    held_sat      = 1'b0;
    gaps_on       = 1'b1;
    ledger        = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // out of reset: disabled with a zero rate, so everything reads zero
    push_req(REQ_READ, 32'hFFFF_FFFF);
    push_req(REQ_TICK, 32'hFFFF_FFFF);
    push_req(REQ_READ, 32'h0);
    push_req(REQ_ELAPSED, 32'hFFFF_FFFF);
    push_req(REQ_ELAP_US, 32'h1234_5678);
    push_req(REQ_CNT_US, 32'hFFFF_FFFF);
    push_req(REQ_CNT_US10, 32'hFFFF_FFFF);
    push_req(REQ_UNUSED, 32'hFFFF_FFFF);

    // one hertz: conversions saturate quickly
    wait_idle();
    write_reg(CFG_CLOCK_HZ, 32'd1);
    write_reg(CFG_TIMER_EN, 32'd1);
    repeat (3) push_req(REQ_TICK, 32'h0);
    push_req(REQ_READ, 32'h0);
    push_req(REQ_ELAPSED, 32'h0);
    push_req(REQ_ELAPSED, 32'hFFFF_FFFF);     // modular wrap of the difference
    push_req(REQ_ELAP_US, 32'd3);
    push_req(REQ_ELAP_US10, 32'd5);           // huge elapsed, clamps
    push_req(REQ_CNT_US, 32'hFFFF_FFFF);
    push_req(REQ_CNT_US10, 32'h0);
    push_req(REQ_CNT_US, 32'd4294);           // just below the clamp
    push_req(REQ_CNT_US, 32'd4295);           // just above it
    push_req(REQ_UNUSED, 32'h0);
    push_req(REQ_READ, 32'h0);

    // largest rate: results shrink towards zero
    wait_idle();
    write_reg(CFG_CLOCK_HZ, 32'hFFFF_FFFF);
    push_req(REQ_CNT_US10, 32'hFFFF_FFFF);
    push_req(REQ_CNT_US, 32'hFFFF_FFFF);

    // random phases over a spread of settings, one without any idling
    run_phase($urandom_range(100_000_000, 1_000_000), 1'b1, 1'b1, 200, 40);
    run_phase(32'd1, 1'b1, 1'b0, 200, 40);
    run_phase(32'hFFFF_FFFF, 1'b0, 1'b1, 150, 35);
    run_phase(32'd0, 1'b1, 1'b1, 150, 35);
    run_phase($urandom(), 1'b1, 1'b1, 250, 40);
    run_phase($urandom_range(1000, 1), 1'b1, 1'b1, 250, 40);
    wait_idle();

    if (ledger.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
